>>> sv/etc1_pkg.sv
// Shared types, constants and helper functions for the ETC1 block decoder.
// Depends on nothing; every other file of the decoder refers to it by scoped names.
`default_nettype none

package etc1_pkg;

  // Bit positions inside the byte-reversed low word of the block.
  localparam int unsigned FlipBit = 24;
  localparam int unsigned DiffBit = 25;

  // Last texel index of a 4x4 block.
  localparam logic [3:0] LastTexel = 4'd15;

  typedef struct packed {
    logic [63:0] color_word;
    logic [63:0] alpha_word;
  } block_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [2:0] column;
    logic [2:0] row;
    logic       last_of_block;
  } texel_t;

  // Position of the texel being decoded: block place in the tile and texel index (row-major).
  typedef struct packed {
    logic [1:0] tile_pos;
    logic [3:0] texel_idx;
  } texel_pos_t;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand4(input logic [3:0] v);
    return {v, v};
  endfunction

  // Base color of one channel for subblock sb; differential sums wrap modulo 32.
  function automatic logic [7:0] base_color(input logic [7:0] byte_v, input logic diff,
                                            input logic sb);
    logic [4:0] delta;
    logic [4:0] second;
    delta  = {{2{byte_v[2]}}, byte_v[2:0]};
    second = byte_v[7:3] + delta;
    if (diff) begin
      return sb ? expand5(second) : expand5(byte_v[7:3]);
    end else begin
      return sb ? expand4(byte_v[3:0]) : expand4(byte_v[7:4]);
    end
  endfunction

  // Intensity modifier table: codeword selects the row, the two selector bits the column.
  function automatic logic signed [8:0] modifier(input logic [2:0] tbl, input logic [1:0] sel);
    logic signed [8:0] mag;
    case (tbl)
      3'd0:    mag = sel[0] ? 9'sd8   : 9'sd2;
      3'd1:    mag = sel[0] ? 9'sd17  : 9'sd5;
      3'd2:    mag = sel[0] ? 9'sd29  : 9'sd9;
      3'd3:    mag = sel[0] ? 9'sd42  : 9'sd13;
      3'd4:    mag = sel[0] ? 9'sd60  : 9'sd18;
      3'd5:    mag = sel[0] ? 9'sd80  : 9'sd24;
      3'd6:    mag = sel[0] ? 9'sd106 : 9'sd33;
      3'd7:    mag = sel[0] ? 9'sd183 : 9'sd47;
      default: mag = 9'sd0;
    endcase
    return sel[1] ? -mag : mag;
  endfunction

  // Adds the modifier to a base color and clamps to 0..255.
  function automatic logic [7:0] apply_mod(input logic [7:0] base,
                                           input logic signed [8:0] m);
    logic signed [9:0] sum;
    sum = $signed({2'b00, base}) + $signed({m[8], m});
    if (sum[9]) begin
      return 8'h00;
    end else if (sum[8]) begin
      return 8'hFF;
    end else begin
      return sum[7:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/etc1_block_decoder_core.sv
// Top level of the ETC1 block decoder: block register, texel decode and result register.
// Depends on etc1_pkg, etc1_blk_reg and etc1_texel.
//
// Usage: one transfer on the input channel (in_valid_i / in_ready_o / in_data_i) carries
// one ETC1 4x4 block: the eight stored color bytes (first byte in bits 7:0) and an
// alpha word of sixteen 4-bit alphas. The block answers with sixteen transfers on the
// output channel (out_valid_o / out_ready_i / out_data_o), one texel each, in row-major
// order, with the texel's column and row inside the 8x8 tile. The last texel of a
// block carries last_of_block. Consecutive blocks fill the tile top-left, top-right,
// bottom-left, bottom-right, then wrap.
// The block register holds the block and the result register captures each decoded
// texel; one texel is produced per cycle unless the receiver stalls, set by the single
// texel decode path between the two registers. The next block is taken in the same
// cycle that its predecessor's last texel enters the result register.
// When the receiver stalls, the result register holds its texel and the block
// register stops stepping; nothing is lost. Reset clears both valid flags, the tile
// position and alpha_enable (alpha reads 255 until cfg_we_i writes cfg_wdata_i).
// Configuration must only be written while no block is in flight.
`default_nettype none

module etc1_block_decoder_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  etc1_pkg::block_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output etc1_pkg::texel_t    out_data_o
);

  logic                   alpha_enable_q;
  logic                   blk_valid;
  etc1_pkg::block_t       blk;
  etc1_pkg::texel_pos_t   pos;
  etc1_pkg::texel_t       texel;
  logic                   step;
  logic                   out_valid_q, out_valid_d;
  etc1_pkg::texel_t       out_data_q;

  // The alpha mode register is a plain write-only flop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      alpha_enable_q <= cfg_wdata_i;
    end
  end

  // A texel moves into the result register whenever a block is held and that register
  // is empty or is being drained in this cycle.
  assign step = blk_valid && (!out_valid_q || out_ready_i);

  etc1_blk_reg u_blk_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .step_i      (step),
    .blk_valid_o (blk_valid),
    .blk_o       (blk),
    .pos_o       (pos)
  );

  etc1_texel u_texel (
    .blk_i          (blk),
    .pos_i          (pos),
    .alpha_enable_i (alpha_enable_q),
    .texel_o        (texel)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= texel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_last_at_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_of_block |->
      out_data_o.column[1:0] == 2'd3 && out_data_o.row[1:0] == 2'd3)
    else $error("last texel of a block is not at the block's bottom-right corner");
`endif

endmodule

`default_nettype wire

>>> sv/etc1_blk_reg.sv
// Block input register with the texel counter and the tile position counter.
// Depends on etc1_pkg for the block and position types.
`default_nettype none

module etc1_blk_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  etc1_pkg::block_t       in_data_i,
  input  logic                   step_i,
  output logic                   blk_valid_o,
  output etc1_pkg::block_t       blk_o,
  output etc1_pkg::texel_pos_t   pos_o
);

  logic                 blk_valid_q, blk_valid_d;
  etc1_pkg::block_t     blk_q;
  logic [3:0]           cnt_q, cnt_d;
  logic [1:0]           pos_q, pos_d;
  logic [1:0]           tile_cnt_q, tile_cnt_d;
  logic                 accept;
  logic                 last_step;

  assign last_step  = step_i && (cnt_q == etc1_pkg::LastTexel);
  assign in_ready_o = !blk_valid_q || last_step;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    blk_valid_d = blk_valid_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    tile_cnt_d  = tile_cnt_q;
    if (accept) begin
      blk_valid_d = 1'b1;
      cnt_d       = 4'd0;
      pos_d       = tile_cnt_q;
      tile_cnt_d  = tile_cnt_q + 2'd1;
    end else if (last_step) begin
      blk_valid_d = 1'b0;
    end else if (step_i) begin
      cnt_d = cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_valid_q <= 1'b0;
      cnt_q       <= 4'd0;
      pos_q       <= 2'd0;
      tile_cnt_q  <= 2'd0;
    end else begin
      blk_valid_q <= blk_valid_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      tile_cnt_q  <= tile_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      blk_q <= in_data_i;
    end
  end

  assign blk_valid_o     = blk_valid_q;
  assign blk_o           = blk_q;
  assign pos_o.tile_pos  = pos_q;
  assign pos_o.texel_idx = cnt_q;

`ifndef ASSERT_OFF
  a_accept_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && blk_valid_q |-> step_i && cnt_q == etc1_pkg::LastTexel)
    else $error("new block taken before the last texel of the current block moved on");

  a_count_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> blk_valid_q && cnt_q == 4'd0)
    else $error("texel counter did not restart on a new block");

  a_tile_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> tile_cnt_q == $past(tile_cnt_q) + 2'd1 && pos_q == $past(tile_cnt_q))
    else $error("tile position did not advance by one block");
`endif

endmodule

`default_nettype wire

>>> sv/etc1_texel.sv
// Combinational decode of one texel from a stored ETC1 block.
// Depends on etc1_pkg for types, bit positions and the modifier table.
`default_nettype none

module etc1_texel (
  input  etc1_pkg::block_t      blk_i,
  input  etc1_pkg::texel_pos_t  pos_i,
  input  logic                  alpha_enable_i,
  output etc1_pkg::texel_t      texel_o
);

  logic [31:0]       hi;
  logic [31:0]       sel;
  logic [1:0]        x;
  logic [1:0]        y;
  logic [3:0]        nib;
  logic [3:0]        bit_idx;
  logic              flip;
  logic              diff;
  logic              sb;
  logic [2:0]        tbl;
  logic [1:0]        msel;
  logic signed [8:0] m;
  logic [3:0]        a_nib;

  // Byte-reversed block: low word holds colors and control, high word the selectors.
  assign hi  = {blk_i.color_word[39:32], blk_i.color_word[47:40],
                blk_i.color_word[55:48], blk_i.color_word[63:56]};
  assign sel = {blk_i.color_word[7:0],   blk_i.color_word[15:8],
                blk_i.color_word[23:16], blk_i.color_word[31:24]};

  assign x       = pos_i.texel_idx[1:0];
  assign y       = pos_i.texel_idx[3:2];
  assign nib     = {x, y};
  // Selector bits are stored with the two byte halves swapped.
  assign bit_idx = {~x[1], x[0], y};

  assign flip = hi[etc1_pkg::FlipBit];
  assign diff = hi[etc1_pkg::DiffBit];
  assign sb   = flip ? y[1] : x[1];
  assign tbl  = sb ? hi[28:26] : hi[31:29];
  assign msel = {sel[{1'b0, bit_idx}], sel[{1'b1, bit_idx}]};
  assign m    = etc1_pkg::modifier(tbl, msel);

  assign a_nib = blk_i.alpha_word[{nib, 2'b00} +: 4];

  assign texel_o.red   = etc1_pkg::apply_mod(etc1_pkg::base_color(hi[23:16], diff, sb), m);
  assign texel_o.green = etc1_pkg::apply_mod(etc1_pkg::base_color(hi[15:8], diff, sb), m);
  assign texel_o.blue  = etc1_pkg::apply_mod(etc1_pkg::base_color(hi[7:0], diff, sb), m);
  assign texel_o.alpha = alpha_enable_i ? {a_nib, a_nib} : 8'hFF;
  assign texel_o.column        = {pos_i.tile_pos[0], x};
  assign texel_o.row           = {pos_i.tile_pos[1], y};
  assign texel_o.last_of_block = (pos_i.texel_idx == etc1_pkg::LastTexel);

endmodule

`default_nettype wire
